[design/miex_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// miex_pkg: shared types and constants for the integer execute unit
// Opcode, funct and REGIMM codes, status codes and the multiply/divide request.
// ----------------------------------------------------------------------------
package miex_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned RIDX = 5;
  localparam int unsigned NREGS = 32;
  localparam logic [31:0] START_ADDRESS_RESET = 32'd0;

  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;

  localparam logic [5:0] FN_SLL   = 6'd0;
  localparam logic [5:0] FN_SRL   = 6'd2;
  localparam logic [5:0] FN_SRA   = 6'd3;
  localparam logic [5:0] FN_SLLV  = 6'd4;
  localparam logic [5:0] FN_SRLV  = 6'd6;
  localparam logic [5:0] FN_SRAV  = 6'd7;
  localparam logic [5:0] FN_JR    = 6'd8;
  localparam logic [5:0] FN_JALR  = 6'd9;
  localparam logic [5:0] FN_MFHI  = 6'd16;
  localparam logic [5:0] FN_MTHI  = 6'd17;
  localparam logic [5:0] FN_MFLO  = 6'd18;
  localparam logic [5:0] FN_MTLO  = 6'd19;
  localparam logic [5:0] FN_MULT  = 6'd24;
  localparam logic [5:0] FN_MULTU = 6'd25;
  localparam logic [5:0] FN_DIV   = 6'd26;
  localparam logic [5:0] FN_DIVU  = 6'd27;
  localparam logic [5:0] FN_ADD   = 6'd32;
  localparam logic [5:0] FN_ADDU  = 6'd33;
  localparam logic [5:0] FN_SUB   = 6'd34;
  localparam logic [5:0] FN_SUBU  = 6'd35;
  localparam logic [5:0] FN_AND   = 6'd36;
  localparam logic [5:0] FN_OR    = 6'd37;
  localparam logic [5:0] FN_XOR   = 6'd38;
  localparam logic [5:0] FN_SLT   = 6'd42;
  localparam logic [5:0] FN_SLTU  = 6'd43;

  localparam logic [4:0] RI_BLTZ   = 5'd0;
  localparam logic [4:0] RI_BGEZ   = 5'd1;
  localparam logic [4:0] RI_BLTZAL = 5'd16;
  localparam logic [4:0] RI_BGEZAL = 5'd17;

  localparam logic [4:0] LINK_REG = 5'd31;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OVF     = 2'd1;
  localparam logic [1:0] ST_UNSUPP  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_MDU, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    MD_MULT, MD_MULTU, MD_DIV, MD_DIVU
  } md_op_t;

  typedef struct packed {
    logic        start;
    md_op_t      op;
    logic [31:0] a;
    logic [31:0] b;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic        busy;
    logic [31:0] hi;
    logic [31:0] lo;
  } md_rsp_t;

endpackage
`default_nettype wire

[design/miex_mdu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// miex_mdu: iterative multiply / divide unit
// Shift-add multiply and restoring divide, one bit per cycle, with sign
// fix-up before and after. Divide by zero keeps HI and LO.
// ----------------------------------------------------------------------------
module miex_mdu (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire miex_pkg::md_req_t req,
  input  wire logic [31:0]      hi_in,
  input  wire logic [31:0]      lo_in,
  output miex_pkg::md_rsp_t     rsp
);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIX, M_DONE} mstate_t;

  mstate_t     mstate;
  logic [5:0]  count;
  logic        is_div;
  logic        neg_q;
  logic        neg_r;
  logic        zero_div;
  logic [31:0] mag_b;
  logic [31:0] acc;
  logic [31:0] shreg;
  logic [31:0] hi_keep;
  logic [31:0] lo_keep;
  logic [31:0] hi_res;
  logic [31:0] lo_res;

  logic        sgn;
  logic [31:0] abs_a;
  logic [31:0] abs_b;
  logic [32:0] add_sum;
  logic [33:0] sub_diff;
  logic [63:0] prod_neg;

  always_comb begin
    sgn   = (req.op == miex_pkg::MD_MULT) || (req.op == miex_pkg::MD_DIV);
    abs_a = (sgn && req.a[31]) ? (32'd0 - req.a) : req.a;
    abs_b = (sgn && req.b[31]) ? (32'd0 - req.b) : req.b;
    add_sum  = {1'b0, acc} + {1'b0, (shreg[0] ? mag_b : 32'd0)};
    sub_diff = {1'b0, acc, shreg[31]} - {2'b00, mag_b};
    prod_neg = 64'd0 - {acc, shreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= M_IDLE;
      count  <= 6'd0;
    end else begin
      case (mstate)
        M_IDLE: begin
          if (req.start) begin
            mstate   <= M_RUN;
            count    <= 6'd0;
            is_div   <= (req.op == miex_pkg::MD_DIV) || (req.op == miex_pkg::MD_DIVU);
            neg_q    <= sgn && (req.a[31] ^ req.b[31]);
            neg_r    <= sgn && req.a[31];
            zero_div <= (req.b == 32'd0);
            mag_b    <= abs_b;
            acc      <= 32'd0;
            shreg    <= abs_a;
            hi_keep  <= hi_in;
            lo_keep  <= lo_in;
          end
        end
        M_RUN: begin
          if (is_div) begin
            if (!sub_diff[33]) begin
              acc   <= sub_diff[31:0];
              shreg <= {shreg[30:0], 1'b1};
            end else begin
              acc   <= {acc[30:0], shreg[31]};
              shreg <= {shreg[30:0], 1'b0};
            end
          end else begin
            acc   <= add_sum[32:1];
            shreg <= {add_sum[0], shreg[31:1]};
          end
          count <= count + 6'd1;
          if (count == 6'd31) mstate <= M_FIX;
        end
        M_FIX: begin
          if (is_div) begin
            if (zero_div) begin
              hi_res <= hi_keep;
              lo_res <= lo_keep;
            end else begin
              lo_res <= neg_q ? (32'd0 - shreg) : shreg;
              hi_res <= neg_r ? (32'd0 - acc) : acc;
            end
          end else if (neg_q) begin
            hi_res <= prod_neg[63:32];
            lo_res <= prod_neg[31:0];
          end else begin
            hi_res <= acc;
            lo_res <= shreg;
          end
          mstate <= M_DONE;
        end
        M_DONE: mstate <= M_IDLE;
        default: mstate <= M_IDLE;
      endcase
    end
  end

  assign rsp.done = (mstate == M_DONE);
  assign rsp.busy = (mstate != M_IDLE);
  assign rsp.hi   = hi_res;
  assign rsp.lo   = lo_res;

endmodule
`default_nettype wire

[design/mips_integer_execute_unit_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mips_integer_execute_unit_top: MIPS I integer execute unit
// Register file in a synchronous RAM, HI/LO, PC and delayed-branch target.
// Sequence: instruction transfer, register read, execute, then result valid;
//   multiply and divide also wait on the iterative unit before the result.
// A new instruction is taken only once the previous result has been accepted.
// Reset: clears the register file RAM, one entry per cycle, during which no
//   instruction is taken; PC loads RESET_ADDRESS.
// ----------------------------------------------------------------------------
module mips_integer_execute_unit_top #(
  parameter logic [31:0] RESET_ADDRESS = miex_pkg::START_ADDRESS_RESET
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] instruction,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      instr_address,
  output logic [1:0]       status,
  output logic             reg_write,
  output logic [4:0]       reg_index,
  output logic [31:0]      reg_value,
  output logic [31:0]      hi_value,
  output logic [31:0]      lo_value,
  output logic [31:0]      next_address
);

  logic [31:0] regs_a [miex_pkg::NREGS];
  logic [31:0] regs_b [miex_pkg::NREGS];

  miex_pkg::state_t state;
  miex_pkg::state_t state_next;

  logic        clearing;
  logic [4:0]  clr_idx;
  logic [31:0] pc;
  logic [31:0] hi;
  logic [31:0] lo;
  logic        br_pend;
  logic [31:0] br_tgt;
  logic [31:0] ins;
  logic [31:0] rd_a;
  logic [31:0] rd_b;

  logic        we;
  logic [4:0]  wi;
  logic [31:0] wv;

  miex_pkg::md_req_t md_req;
  miex_pkg::md_rsp_t md_rsp;

  logic [5:0]  op;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [5:0]  fn;
  logic [15:0] imm;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] simm;
  logic [31:0] slot;
  logic [31:0] link;
  logic [31:0] bt;
  logic [31:0] s;
  logic [31:0] nxt;
  logic [1:0]  e_st;
  logic        e_wr;
  logic [4:0]  e_wi;
  logic [31:0] e_wv;
  logic        e_take;
  logic [31:0] e_tgt;
  logic        e_md;
  miex_pkg::md_op_t e_mdop;
  logic        e_mthi;
  logic        e_mtlo;

  assign op  = ins[31:26];
  assign rs  = ins[25:21];
  assign rt  = ins[20:16];
  assign rd  = ins[15:11];
  assign sh  = ins[10:6];
  assign fn  = ins[5:0];
  assign imm = ins[15:0];
  assign a   = (rs == 5'd0) ? 32'd0 : rd_a;
  assign b   = (rt == 5'd0) ? 32'd0 : rd_b;
  assign simm = {{16{imm[15]}}, imm};
  assign slot = pc + 32'd4;
  assign link = pc + 32'd8;
  assign bt   = slot + {simm[29:0], 2'b00};
  assign nxt  = br_pend ? br_tgt : slot;

  always_comb begin
    e_st = miex_pkg::ST_OK; e_wr = 1'b0; e_wi = 5'd0; e_wv = 32'd0;
    e_take = 1'b0; e_tgt = bt; e_md = 1'b0; e_mdop = miex_pkg::MD_MULT;
    e_mthi = 1'b0; e_mtlo = 1'b0; s = 32'd0;
    case (op)
      miex_pkg::OP_SPECIAL: begin
        e_wi = rd; e_wr = 1'b1;
        case (fn)
          miex_pkg::FN_ADD: begin
            s = a + b;
            if (((a ^ s) & (b ^ s) & 32'h8000_0000) != 32'd0) begin
              e_st = miex_pkg::ST_OVF; e_wr = 1'b0;
            end else e_wv = s;
          end
          miex_pkg::FN_ADDU: e_wv = a + b;
          miex_pkg::FN_SUB: begin
            s = a - b;
            if (((a ^ b) & (a ^ s) & 32'h8000_0000) != 32'd0) begin
              e_st = miex_pkg::ST_OVF; e_wr = 1'b0;
            end else e_wv = s;
          end
          miex_pkg::FN_SUBU: e_wv = a - b;
          miex_pkg::FN_AND:  e_wv = a & b;
          miex_pkg::FN_OR:   e_wv = a | b;
          miex_pkg::FN_XOR:  e_wv = a ^ b;
          miex_pkg::FN_SLT:  e_wv = {31'd0, $signed(a) < $signed(b)};
          miex_pkg::FN_SLTU: e_wv = {31'd0, a < b};
          miex_pkg::FN_SLL:  e_wv = b << sh;
          miex_pkg::FN_SRL:  e_wv = b >> sh;
          miex_pkg::FN_SRA:  e_wv = 32'($signed(b) >>> sh);
          miex_pkg::FN_SLLV: e_wv = b << a[4:0];
          miex_pkg::FN_SRLV: e_wv = b >> a[4:0];
          miex_pkg::FN_SRAV: e_wv = 32'($signed(b) >>> a[4:0]);
          miex_pkg::FN_MFHI: e_wv = hi;
          miex_pkg::FN_MFLO: e_wv = lo;
          miex_pkg::FN_MTHI: begin e_mthi = 1'b1; e_wr = 1'b0; end
          miex_pkg::FN_MTLO: begin e_mtlo = 1'b1; e_wr = 1'b0; end
          miex_pkg::FN_MULT: begin e_md = 1'b1; e_mdop = miex_pkg::MD_MULT; e_wr = 1'b0; end
          miex_pkg::FN_MULTU: begin e_md = 1'b1; e_mdop = miex_pkg::MD_MULTU; e_wr = 1'b0; end
          miex_pkg::FN_DIV:  begin e_md = 1'b1; e_mdop = miex_pkg::MD_DIV; e_wr = 1'b0; end
          miex_pkg::FN_DIVU: begin e_md = 1'b1; e_mdop = miex_pkg::MD_DIVU; e_wr = 1'b0; end
          miex_pkg::FN_JR:   begin e_take = 1'b1; e_tgt = a; e_wr = 1'b0; end
          miex_pkg::FN_JALR: begin e_take = 1'b1; e_tgt = a; e_wv = link; end
          default: begin e_st = miex_pkg::ST_UNSUPP; e_wr = 1'b0; end
        endcase
      end
      miex_pkg::OP_REGIMM: begin
        e_wi = miex_pkg::LINK_REG; e_wv = link;
        case (rt)
          miex_pkg::RI_BLTZ:   e_take = a[31];
          miex_pkg::RI_BGEZ:   e_take = !a[31];
          miex_pkg::RI_BLTZAL: begin e_take = a[31]; e_wr = 1'b1; end
          miex_pkg::RI_BGEZAL: begin e_take = !a[31]; e_wr = 1'b1; end
          default: e_st = miex_pkg::ST_UNSUPP;
        endcase
      end
      miex_pkg::OP_J, miex_pkg::OP_JAL: begin
        e_take = 1'b1;
        e_tgt = {slot[31:28], ins[25:0], 2'b00};
        if (op == miex_pkg::OP_JAL) begin
          e_wr = 1'b1; e_wi = miex_pkg::LINK_REG; e_wv = link;
        end
      end
      default: begin
        e_wi = rt; e_wr = 1'b1;
        case (op)
          miex_pkg::OP_BEQ:  begin e_take = (a == b); e_wr = 1'b0; end
          miex_pkg::OP_BNE:  begin e_take = (a != b); e_wr = 1'b0; end
          miex_pkg::OP_BLEZ: begin e_take = (a == 32'd0) || a[31]; e_wr = 1'b0; end
          miex_pkg::OP_BGTZ: begin e_take = (a != 32'd0) && !a[31]; e_wr = 1'b0; end
          miex_pkg::OP_ADDI: begin
            s = a + simm;
            if (((a ^ s) & (simm ^ s) & 32'h8000_0000) != 32'd0) begin
              e_st = miex_pkg::ST_OVF; e_wr = 1'b0;
            end else e_wv = s;
          end
          miex_pkg::OP_ADDIU: e_wv = a + simm;
          miex_pkg::OP_SLTI:  e_wv = {31'd0, $signed(a) < $signed(simm)};
          miex_pkg::OP_SLTIU: e_wv = {31'd0, a < simm};
          miex_pkg::OP_ANDI:  e_wv = a & {16'd0, imm};
          miex_pkg::OP_ORI:   e_wv = a | {16'd0, imm};
          miex_pkg::OP_XORI:  e_wv = a ^ {16'd0, imm};
          miex_pkg::OP_LUI:   e_wv = {imm, 16'd0};
          default: begin e_st = miex_pkg::ST_UNSUPP; e_wr = 1'b0; end
        endcase
      end
    endcase
    if (e_wi == 5'd0) e_wr = 1'b0;
    if (!e_wr) begin
      e_wi = 5'd0; e_wv = 32'd0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      miex_pkg::S_IDLE: if (in_valid && in_ready) state_next = miex_pkg::S_READ;
      miex_pkg::S_READ: state_next = miex_pkg::S_EXEC;
      miex_pkg::S_EXEC: state_next = e_md ? miex_pkg::S_MDU : miex_pkg::S_OUT;
      miex_pkg::S_MDU:  if (md_rsp.done) state_next = miex_pkg::S_OUT;
      miex_pkg::S_OUT:  if (out_ready) state_next = miex_pkg::S_IDLE;
      default: state_next = miex_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == miex_pkg::S_IDLE) && !clearing;
    out_valid = (state == miex_pkg::S_OUT);
    md_req.start = (state == miex_pkg::S_EXEC) && e_md;
    md_req.op = e_mdop;
    md_req.a  = a;
    md_req.b  = b;
    we = clearing || ((state == miex_pkg::S_EXEC) && e_wr);
    wi = clearing ? clr_idx : e_wi;
    wv = clearing ? 32'd0 : e_wv;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      regs_a[wi] <= wv;
      regs_b[wi] <= wv;
    end
    rd_a <= regs_a[ins[25:21]];
    rd_b <= regs_b[ins[20:16]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= miex_pkg::S_IDLE;
      clearing <= 1'b1;
      clr_idx  <= 5'd0;
      pc       <= RESET_ADDRESS;
      hi       <= 32'd0;
      lo       <= 32'd0;
      br_pend  <= 1'b0;
      br_tgt   <= 32'd0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= clr_idx + 5'd1;
        if (clr_idx == 5'd31) clearing <= 1'b0;
      end
      if (cfg_we) pc <= cfg_wdata;
      if (in_valid && in_ready) ins <= instruction;
      if (state == miex_pkg::S_EXEC) begin
        instr_address <= pc;
        status        <= e_st;
        reg_write     <= e_wr;
        reg_index     <= e_wi;
        reg_value     <= e_wv;
        next_address  <= nxt;
        pc            <= nxt;
        br_pend       <= e_take;
        if (e_take) br_tgt <= e_tgt;
        if (e_mthi) hi <= a;
        if (e_mtlo) lo <= a;
      end
      if (md_rsp.done) begin
        hi <= md_rsp.hi;
        lo <= md_rsp.lo;
      end
    end
  end

  assign hi_value = hi;
  assign lo_value = lo;

  miex_mdu u_mdu (
    .clk   (clk),
    .rst   (rst),
    .req   (md_req),
    .hi_in (hi),
    .lo_in (lo),
    .rsp   (md_rsp)
  );

endmodule
`default_nettype wire

[design/miex_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// miex_checker: port-level checks for the integer execute unit
// Handshake and result sanity over time, bound to the top level.
// ----------------------------------------------------------------------------
module miex_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic        reg_write,
  input wire logic [4:0]  reg_index,
  input wire logic [31:0] reg_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(reg_value))
    else $error("result changed while stalled");

  a_no_r0: assert property (@(posedge clk) disable iff (rst)
    out_valid && reg_write |-> reg_index != 5'd0)
    else $error("write to register zero reported");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != 2'd0 |-> !reg_write)
    else $error("write reported with failing status");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("second transfer taken while item in flight");

endmodule

bind mips_integer_execute_unit_top miex_checker u_miex_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .reg_write (reg_write),
  .reg_index (reg_index),
  .reg_value (reg_value)
);
`default_nettype wire

[bench/mips_integer_execute_unit_top_tb.sv]
// ----------------------------------------------------------------------------
// mips_integer_execute_unit_top_tb: self-checking bench for the execute unit
// Drives MIPS I instruction words over a valid/ready channel. A scoreboard
// class keeps its own copy of the registers, HI/LO, PC and the delay-slot
// target, and checks every result transfer in order. The start address is
// rewritten between phases, and the bench runs with and without idling.
// ----------------------------------------------------------------------------
module mips_integer_execute_unit_top_tb;
  import miex_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] addr;
    logic [1:0]  st;
    logic        wr;
    logic [4:0]  idx;
    logic [31:0] val;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] nxt;
  } exec_result_t;

  class exec_scoreboard;
    logic [31:0] gpr[32];
    logic [31:0] hi, lo, pc, tgt;
    logic        pend;
    exec_result_t pending_results[$];
    int errors;
    int mismatches;

    function void clear();
      foreach (gpr[i]) gpr[i] = '0;
      hi = '0; lo = '0; pc = START_ADDRESS_RESET; tgt = '0; pend = 1'b0;
      errors = 0; mismatches = 0;
    endfunction

    function void set_start(logic [31:0] v);
      pc = v;
    endfunction

    function logic [31:0] sx(logic [15:0] v);
      return {{16{v[15]}}, v};
    endfunction

    function void note_instruction(logic [31:0] ins);
      exec_result_t r;
      logic [5:0] op, fn;
      logic [4:0] rs, rt, rd, sh;
      logic [31:0] a, b, s, c, slot, nxt, wv, tg, ma, mb, q, rm;
      logic [4:0] wi;
      logic [1:0] st;
      logic wr, take;
      longint sa, sb, p;
      logic [63:0] up;
      op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
      sh = ins[10:6]; fn = ins[5:0];
      a = gpr[rs]; b = gpr[rt];
      slot = pc + 32'd4;
      st = ST_OK; wi = '0; wv = '0; wr = 1'b0; take = 1'b0; tg = '0;
      if (pend) begin
        nxt = tgt; pend = 1'b0;
      end else begin
        nxt = slot;
      end
      if (op == OP_SPECIAL) begin
        wi = rd; wr = 1'b1;
        case (fn)
          FN_ADD: begin
            s = a + b;
            if (((a ^ s) & (b ^ s)) >> 31) begin st = ST_OVF; wr = 1'b0; end
            else wv = s;
          end
          FN_ADDU: wv = a + b;
          FN_SUB: begin
            s = a - b;
            if (((a ^ b) & (a ^ s)) >> 31) begin st = ST_OVF; wr = 1'b0; end
            else wv = s;
          end
          FN_SUBU: wv = a - b;
          FN_AND:  wv = a & b;
          FN_OR:   wv = a | b;
          FN_XOR:  wv = a ^ b;
          FN_SLT:  wv = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          FN_SLTU: wv = (a < b) ? 32'd1 : 32'd0;
          FN_SLL:  wv = b << sh;
          FN_SRL:  wv = b >> sh;
          FN_SRA:  wv = $signed(b) >>> sh;
          FN_SLLV: wv = b << a[4:0];
          FN_SRLV: wv = b >> a[4:0];
          FN_SRAV: wv = $signed(b) >>> a[4:0];
          FN_MFHI: wv = hi;
          FN_MFLO: wv = lo;
          FN_MTHI: begin hi = a; wr = 1'b0; end
          FN_MTLO: begin lo = a; wr = 1'b0; end
          FN_MULT: begin
            sa = $signed(a); sb = $signed(b); p = sa * sb;
            lo = p[31:0]; hi = p[63:32]; wr = 1'b0;
          end
          FN_MULTU: begin
            up = {32'd0, a} * {32'd0, b};
            lo = up[31:0]; hi = up[63:32]; wr = 1'b0;
          end
          FN_DIV: begin
            if (b != 0) begin
              ma = a[31] ? -a : a;
              mb = b[31] ? -b : b;
              q = ma / mb; rm = ma % mb;
              lo = (a[31] ^ b[31]) ? -q : q;
              hi = a[31] ? -rm : rm;
            end
            wr = 1'b0;
          end
          FN_DIVU: begin
            if (b != 0) begin lo = a / b; hi = a % b; end
            wr = 1'b0;
          end
          FN_JR:   begin take = 1'b1; tg = a; wr = 1'b0; end
          FN_JALR: begin take = 1'b1; tg = a; wv = pc + 32'd8; end
          default: begin st = ST_UNSUPP; wr = 1'b0; end
        endcase
      end else if (op == OP_REGIMM) begin
        tg = slot + (sx(ins[15:0]) << 2);
        wi = LINK_REG; wv = pc + 32'd8;
        case (rt)
          RI_BLTZ:   take = a[31];
          RI_BGEZ:   take = !a[31];
          RI_BLTZAL: begin take = a[31]; wr = 1'b1; end
          RI_BGEZAL: begin take = !a[31]; wr = 1'b1; end
          default:   st = ST_UNSUPP;
        endcase
      end else if (op == OP_J || op == OP_JAL) begin
        take = 1'b1;
        tg = {slot[31:28], ins[25:0], 2'b00};
        if (op == OP_JAL) begin wr = 1'b1; wi = LINK_REG; wv = pc + 32'd8; end
      end else begin
        wi = rt; wr = 1'b1;
        tg = slot + (sx(ins[15:0]) << 2);
        case (op)
          OP_BEQ:  begin take = (a == b); wr = 1'b0; end
          OP_BNE:  begin take = (a != b); wr = 1'b0; end
          OP_BLEZ: begin take = (a == 0) || a[31]; wr = 1'b0; end
          OP_BGTZ: begin take = (a != 0) && !a[31]; wr = 1'b0; end
          OP_ADDI: begin
            c = sx(ins[15:0]); s = a + c;
            if (((a ^ s) & (c ^ s)) >> 31) begin st = ST_OVF; wr = 1'b0; end
            else wv = s;
          end
          OP_ADDIU: wv = a + sx(ins[15:0]);
          OP_SLTI:  wv = ($signed(a) < $signed(sx(ins[15:0]))) ? 32'd1 : 32'd0;
          OP_SLTIU: wv = (a < sx(ins[15:0])) ? 32'd1 : 32'd0;
          OP_ANDI:  wv = a & {16'd0, ins[15:0]};
          OP_ORI:   wv = a | {16'd0, ins[15:0]};
          OP_XORI:  wv = a ^ {16'd0, ins[15:0]};
          OP_LUI:   wv = {ins[15:0], 16'd0};
          default:  begin st = ST_UNSUPP; wr = 1'b0; end
        endcase
      end
      if (wr && wi == 0) wr = 1'b0;
      if (wr) gpr[wi] = wv;
      else begin wi = '0; wv = '0; end
      if (take) begin pend = 1'b1; tgt = tg; end
      r.addr = pc; r.st = st; r.wr = wr; r.idx = wi; r.val = wv;
      r.hi = hi; r.lo = lo; r.nxt = nxt;
      pc = nxt;
      pending_results.push_back(r);
    endfunction

    function void check_result(exec_result_t got);
      exec_result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        if (mismatches++ < 10)
          $display("unexpected result transfer at addr %h", got.addr);
        return;
      end
      e = pending_results.pop_front();
      if (got.addr !== e.addr || got.st !== e.st || got.wr !== e.wr ||
          got.idx !== e.idx || got.val !== e.val || got.hi !== e.hi ||
          got.lo !== e.lo || got.nxt !== e.nxt) begin
        errors++;
        if (mismatches++ < 10) begin
          $display("mismatch exp: addr %h st %0d wr %b idx %0d val %h hi %h lo %h nxt %h",
                   e.addr, e.st, e.wr, e.idx, e.val, e.hi, e.lo, e.nxt);
          $display("         got: addr %h st %0d wr %b idx %0d val %h hi %h lo %h nxt %h",
                   got.addr, got.st, got.wr, got.idx, got.val, got.hi, got.lo, got.nxt);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] instruction = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] instr_address, reg_value, hi_value, lo_value, next_address;
  logic [1:0]  status;
  logic        reg_write;
  logic [4:0]  reg_index;

  exec_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;

  mips_integer_execute_unit_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .instruction(instruction),
    .out_valid(out_valid), .out_ready(out_ready),
    .instr_address(instr_address), .status(status), .reg_write(reg_write),
    .reg_index(reg_index), .reg_value(reg_value), .hi_value(hi_value),
    .lo_value(lo_value), .next_address(next_address)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("** mips_integer_execute_unit_top: FAILED **");
    $finish;
  end

  // result side: stalls, long hold-offs, checking
  initial begin
    exec_result_t got;
    int hold_served, hold_left;
    hold_served = 0; hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.addr = instr_address; got.st = status; got.wr = reg_write;
        got.idx = reg_index; got.val = reg_value; got.hi = hi_value;
        got.lo = lo_value; got.nxt = next_address;
        sb.check_result(got);
      end
    end
  end

  function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sh);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(1) != 0) ? 5'($urandom_range(7)) : 5'($urandom);
  endfunction

  function automatic logic [15:0] pick_imm();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h8000;
      3: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_instruction();
    logic [5:0] rfn[19] = '{FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR,
                            FN_SLT, FN_SLTU, FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV,
                            FN_SRAV, FN_MFHI, FN_MFLO, FN_MTHI, FN_MTLO};
    logic [5:0] mfn[4] = '{FN_MULT, FN_MULTU, FN_DIV, FN_DIVU};
    logic [4:0] rim[4] = '{RI_BLTZ, RI_BGEZ, RI_BLTZAL, RI_BGEZAL};
    int k;
    k = $urandom_range(99);
    if (k < 32)
      return rtype(rfn[$urandom_range(18)], pick_reg(), pick_reg(), pick_reg(),
                   5'($urandom));
    if (k < 60)
      return itype(6'($urandom_range(OP_ADDI, OP_LUI)), pick_reg(), pick_reg(), pick_imm());
    if (k < 67)
      return rtype(mfn[$urandom_range(3)], pick_reg(), pick_reg(), 5'd0, 5'd0);
    if (k < 73)
      return itype(6'($urandom_range(OP_BEQ, OP_BGTZ)), pick_reg(), pick_reg(), pick_imm());
    if (k < 77)
      return itype(OP_REGIMM, pick_reg(), rim[$urandom_range(3)], pick_imm());
    if (k < 81)
      return {($urandom_range(1) != 0) ? OP_J : OP_JAL, 26'($urandom)};
    if (k < 85)
      return rtype(($urandom_range(1) != 0) ? FN_JR : FN_JALR, pick_reg(), 5'd0,
                   pick_reg(), 5'd0);
    if (k < 90)
      return itype(6'($urandom_range(6'h20, 6'h2e)), pick_reg(), pick_reg(), pick_imm());
    return $urandom;
  endfunction

  task automatic send_instruction(logic [31:0] ins);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    in_valid = 1'b1;
    instruction = ins;
    do @(posedge clk); while (!in_ready);
    sb.note_instruction(ins);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_start(logic [31:0] v);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_start(v);
  endtask

  initial begin
    logic [31:0] directed[$];
    logic [31:0] starts[4];
    int pct_send[4] = '{0, 84, 0, 33};
    int pct_recv[4] = '{0, 0, 84, 33};
    sb.clear();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (40) @(negedge clk);
    write_start(32'hffff_fff0);

    directed = '{
      itype(OP_LUI, 5'd0, 5'd1, 16'h8000),
      itype(OP_ADDIU, 5'd0, 5'd2, 16'hffff),
      itype(OP_ORI, 5'd0, 5'd3, 16'hffff),
      itype(OP_LUI, 5'd0, 5'd4, 16'h7fff),
      itype(OP_ORI, 5'd4, 5'd4, 16'hffff),
      rtype(FN_ADD, 5'd4, 5'd4, 5'd5, 5'd0),
      rtype(FN_SUB, 5'd1, 5'd4, 5'd5, 5'd0),
      itype(OP_ADDI, 5'd4, 5'd5, 16'h0001),
      rtype(FN_ADDU, 5'd4, 5'd4, 5'd0, 5'd0),
      rtype(FN_DIV, 5'd1, 5'd2, 5'd0, 5'd0),
      rtype(FN_DIV, 5'd4, 5'd0, 5'd0, 5'd0),
      rtype(FN_MULT, 5'd1, 5'd2, 5'd0, 5'd0),
      rtype(FN_MULTU, 5'd2, 5'd2, 5'd0, 5'd0),
      rtype(FN_MFHI, 5'd0, 5'd0, 5'd6, 5'd0),
      rtype(FN_SRA, 5'd0, 5'd1, 5'd7, 5'd31),
      rtype(FN_SLT, 5'd1, 5'd4, 5'd8, 5'd0),
      itype(OP_SLTIU, 5'd4, 5'd9, 16'h8000),
      itype(OP_BEQ, 5'd0, 5'd0, 16'hffff),
      itype(OP_BNE, 5'd1, 5'd2, 16'h7fff),
      {OP_JAL, 26'h3ff_ffff},
      itype(OP_REGIMM, 5'd1, RI_BLTZAL, 16'h8000),
      rtype(FN_JALR, 5'd2, 5'd0, 5'd31, 5'd0),
      rtype(FN_JR, 5'd4, 5'd0, 5'd0, 5'd0),
      itype(6'h23, 5'd1, 5'd2, 16'h0004),
      itype(OP_REGIMM, 5'd1, 5'd2, 16'h0000),
      rtype(6'd1, 5'd1, 5'd2, 5'd3, 5'd0)
    };
    foreach (directed[i]) send_instruction(directed[i]);
    wait_drained();

    starts = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_fffc, $urandom};
    for (int ph = 0; ph < 4; ph++) begin
      write_start(starts[ph]);
      idle_pct = pct_send[ph];
      stall_pct = pct_recv[ph];
      for (int n = 0; n < 225; n++) begin
        if (ph == 0 && n == 60) hold_requests++;
        if (ph == 0 && n == 150) wait_drained();
        send_instruction(random_instruction());
      end
      wait_drained();
    end
    idle_pct = 0;
    stall_pct = 0;
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("** mips_integer_execute_unit_top: PASSED **");
    else
      $display("** mips_integer_execute_unit_top: FAILED **");
    $finish;
  end
endmodule
